/* hw/rtl/ppr_pkg.sv */
// ============================================================================
// ppr_pkg: shared types and constants of the primary ray direction core
// Register indexes, fixed field widths and the sideband word that travels
// from normalization through the square root and the dividers.
// ============================================================================
package ppr_pkg;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 48;

  // Fixed field widths.
  localparam int JIT_BITS   = 9;   // signed Q1.8 jitter
  localparam int INV_BITS   = 25;  // unsigned Q1.24 reciprocal
  localparam int SCALE_BITS = 24;  // unsigned Q8.16 scale
  localparam int DXY_BITS   = 39;  // scaled screen offset, saturated to +-2^37
  localparam int MAG_BITS   = 31;  // normalized magnitude, at most 2^30
  localparam int SQ_BITS    = 62;  // sum of three squares of normalized values
  localparam int LEN_BITS   = 32;  // vector length after normalization

  // Register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_RIGHT   = 3'd0,
    REG_UP      = 3'd1,
    REG_FORWARD = 3'd2,
    REG_INV_W   = 3'd3,
    REG_INV_H   = 3'd4,
    REG_TAN     = 3'd5,
    REG_ASPECT  = 3'd6
  } ppr_reg_t;

  // Sideband word: magnitudes and signs of the normalized components.
  typedef struct packed {
    logic                      zero;
    logic [2:0]                neg;
    logic [2:0][MAG_BITS-1:0]  mag;
  } ppr_side_t;

endpackage

/* hw/rtl/ppr_ndc.sv */
// ============================================================================
// ppr_ndc: pixel to scaled screen offset
// Five pipeline stages: sample position, reciprocal products, NDC with
// saturation, field of view products, and the saturated offsets dx and dy.
// ============================================================================
module ppr_ndc #(
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [COORD_BITS-1:0]                pixel_x,
  input  logic [COORD_BITS-1:0]                pixel_y,
  input  logic signed [ppr_pkg::JIT_BITS-1:0]  jitter_x,
  input  logic signed [ppr_pkg::JIT_BITS-1:0]  jitter_y,
  input  logic [ppr_pkg::INV_BITS-1:0]         inv_width,
  input  logic [ppr_pkg::INV_BITS-1:0]         inv_height,
  input  logic [ppr_pkg::SCALE_BITS-1:0]       tan_half_fov,
  input  logic [ppr_pkg::SCALE_BITS-1:0]       aspect_ratio,
  output logic                                 out_valid,
  output logic signed [ppr_pkg::DXY_BITS-1:0]  dx,
  output logic signed [ppr_pkg::DXY_BITS-1:0]  dy
);
  import ppr_pkg::*;

  localparam int FW = COORD_BITS + 10;      // sample position in Q.8
  localparam int PW = FW + INV_BITS + 1;    // position times reciprocal
  localparam int NW = PW + 2;               // NDC numerator
  localparam int MW = 65;                   // NDC times scale
  localparam logic signed [NW-1:0] TWO32  = NW'(64'h1_0000_0000);
  localparam logic signed [NW-1:0] NLIM   = NW'(64'h4000_0000);
  localparam logic signed [31:0]   LIM32  = 32'sh4000_0000;
  localparam logic signed [MW-1:0] MLIM   = MW'(64'h20_0000_0000);
  localparam logic signed [DXY_BITS-1:0] DLIM = DXY_BITS'(64'h20_0000_0000);

  logic [4:0] valid;

  logic signed [FW-1:0] fx, fy;
  logic signed [PW-1:0] px, py;
  logic [2*SCALE_BITS-1:0] sxp;
  logic signed [31:0] ndcx, ndcy;
  logic [31:0] sx;
  logic signed [MW-1:0] mx, my;

  logic signed [NW-1:0] numx, numy, shx, shy;
  logic signed [MW-1:0] shmx, shmy;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[3:0], in_valid};
    end
  end

  // NDC numerators; the Y axis is flipped.
  always_comb begin
    numx = {px[PW-1], px, 1'b0} - TWO32;
    numy = TWO32 - {py[PW-1], py, 1'b0};
    shx  = numx >>> 16;
    shy  = numy >>> 16;
    shmx = mx >>> 16;
    shmy = my >>> 16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Pixel center plus jitter.
      fx <= signed'({2'b00, pixel_x, 8'd128}) + {{(FW-JIT_BITS){jitter_x[JIT_BITS-1]}}, jitter_x};
      fy <= signed'({2'b00, pixel_y, 8'd128}) + {{(FW-JIT_BITS){jitter_y[JIT_BITS-1]}}, jitter_y};
      // Reciprocal products and the horizontal scale.
      px  <= fx * signed'({1'b0, inv_width});
      py  <= fy * signed'({1'b0, inv_height});
      sxp <= aspect_ratio * tan_half_fov;
      // Saturated NDC.
      if (shx > NLIM) begin
        ndcx <= LIM32;
      end else if (shx < -NLIM) begin
        ndcx <= -LIM32;
      end else begin
        ndcx <= shx[31:0];
      end
      if (shy > NLIM) begin
        ndcy <= LIM32;
      end else if (shy < -NLIM) begin
        ndcy <= -LIM32;
      end else begin
        ndcy <= shy[31:0];
      end
      sx <= sxp[47:16];
      // Field of view products.
      mx <= ndcx * signed'({1'b0, sx});
      my <= ndcy * signed'({1'b0, tan_half_fov});
      // Saturated screen offsets.
      if (shmx > MLIM) begin
        dx <= DLIM;
      end else if (shmx < -MLIM) begin
        dx <= -DLIM;
      end else begin
        dx <= shmx[DXY_BITS-1:0];
      end
      if (shmy > MLIM) begin
        dy <= DLIM;
      end else if (shmy < -MLIM) begin
        dy <= -DLIM;
      end else begin
        dy <= shmy[DXY_BITS-1:0];
      end
    end
  end

  assign out_valid = valid[4];

endmodule

/* hw/rtl/ppr_norm.sv */
// ============================================================================
// ppr_norm: basis combination and normalization
// Seven stages: basis products, vector sum, magnitude bound, leading one,
// normalizing shift, squares and the sum of squares.
// ============================================================================
module ppr_norm #(
  parameter int VEC_FRAC_BITS = 14
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic                                     in_valid,
  input  logic signed [ppr_pkg::DXY_BITS-1:0]      dx,
  input  logic signed [ppr_pkg::DXY_BITS-1:0]      dy,
  input  logic [ppr_pkg::CFG_DATA_BITS-1:0]        right_vector,
  input  logic [ppr_pkg::CFG_DATA_BITS-1:0]        up_vector,
  input  logic [ppr_pkg::CFG_DATA_BITS-1:0]        forward_vector,
  output logic                                     out_valid,
  output logic [ppr_pkg::SQ_BITS-1:0]              sumsq,
  output ppr_pkg::ppr_side_t                       side
);
  import ppr_pkg::*;

  localparam int CB  = VEC_FRAC_BITS + 2;
  localparam int EXT = 3 * CB + CFG_DATA_BITS;
  localparam int PRW = CB + DXY_BITS;
  localparam int VW  = CB + DXY_BITS + 2;
  localparam int PB  = $clog2(VW);
  localparam logic [PB-1:0] TOP_POS = PB'(29);

  logic [6:0] valid;

  logic [EXT-1:0] rx, ux, fxv;
  logic signed [CB-1:0]  cr [3], cu [3], cf [3];
  logic signed [PRW-1:0] pr [3], pu [3];
  logic signed [CB-1:0]  pf [3];
  logic signed [VW-1:0]  v7 [3], v8 [3], v9 [3];
  logic [VW-1:0]         absv [3];
  logic [VW-1:0]         m;
  logic [PB-1:0]         p, p_next;
  logic                  zero9;
  logic signed [VW-1:0]  t [3];
  logic signed [31:0]    vn [3], nvn [3];
  logic [SQ_BITS-1:0]    sq [3];
  ppr_side_t             side10, side11;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[5:0], in_valid};
    end
  end

  // Component extraction; bits above the register read as zero.
  assign rx  = {{(3*CB){1'b0}}, right_vector};
  assign ux  = {{(3*CB){1'b0}}, up_vector};
  assign fxv = {{(3*CB){1'b0}}, forward_vector};

  // Leading one of the bound on all magnitudes.
  always_comb begin
    p_next = '0;
    for (int j = 0; j < VW; j++) begin
      if (m[j]) begin
        p_next = PB'(j);
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign cr[i] = signed'(rx[i*CB +: CB]);
    assign cu[i] = signed'(ux[i*CB +: CB]);
    assign cf[i] = signed'(fxv[i*CB +: CB]);
    assign absv[i] = v7[i][VW-1] ? VW'(-v7[i]) : VW'(v7[i]);

    // Shift so that the largest magnitude lands in [2^29, 2^30).
    always_comb begin
      if (p > TOP_POS) begin
        t[i] = v9[i] >>> (p - TOP_POS);
      end else begin
        t[i] = v9[i] <<< (TOP_POS - p);
      end
      vn[i]  = t[i][31:0];
      nvn[i] = -vn[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pr[i] <= cr[i] * dx;
        pu[i] <= cu[i] * dy;
        pf[i] <= cf[i];
        v7[i] <= {{(VW-PRW){pr[i][PRW-1]}}, pr[i]} + {{(VW-PRW){pu[i][PRW-1]}}, pu[i]}
               + ({{(VW-CB){pf[i][CB-1]}}, pf[i]} <<< 16);
        v8[i] <= v7[i];
        v9[i] <= v8[i];
        side10.neg[i] <= vn[i][31];
        side10.mag[i] <= vn[i][31] ? nvn[i][MAG_BITS-1:0] : vn[i][MAG_BITS-1:0];
        sq[i] <= {{(SQ_BITS-MAG_BITS){1'b0}}, side10.mag[i]}
               * {{(SQ_BITS-MAG_BITS){1'b0}}, side10.mag[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m           <= absv[0] | absv[1] | absv[2];
      p           <= p_next;
      zero9       <= (m == '0);
      side10.zero <= zero9;
      side11      <= side10;
      side        <= side11;
      sumsq       <= sq[0] + sq[1] + sq[2];
    end
  end

  assign out_valid = valid[6];

endmodule

/* hw/rtl/ppr_isqrt.sv */
// ============================================================================
// ppr_isqrt: pipelined integer square root
// One result bit per stage over 32 stages, the sideband word riding along.
// ============================================================================
module ppr_isqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [ppr_pkg::SQ_BITS-1:0]     radicand,
  input  ppr_pkg::ppr_side_t              in_side,
  output logic                            out_valid,
  output logic [ppr_pkg::LEN_BITS-1:0]    root,
  output ppr_pkg::ppr_side_t              out_side
);
  import ppr_pkg::*;

  localparam int STAGES = 32;

  logic [63:0]  x    [STAGES+1];
  logic [63:0]  res  [STAGES+1];
  ppr_side_t    sd   [STAGES+1];
  logic [STAGES:0] valid;

  assign x[0]     = {{(64-SQ_BITS){1'b0}}, radicand};
  assign res[0]   = '0;
  assign sd[0]    = in_side;
  assign valid[0] = in_valid;

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
    logic [63:0] trial;
    assign trial = res[k] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (en) begin
        valid[k+1] <= valid[k];
      end
    end

    // Restoring step: keep the bit when the remainder allows it.
    always_ff @(posedge clk) begin
      if (en) begin
        sd[k+1] <= sd[k];
        if (x[k] >= trial) begin
          x[k+1]   <= x[k] - trial;
          res[k+1] <= (res[k] >> 1) + BIT;
        end else begin
          x[k+1]   <= x[k];
          res[k+1] <= res[k] >> 1;
        end
      end
    end
  end

  assign out_valid = valid[STAGES];
  assign root      = res[STAGES][LEN_BITS-1:0];
  assign out_side  = sd[STAGES];

endmodule

/* hw/rtl/ppr_div.sv */
// ============================================================================
// ppr_div: pipelined rounding dividers
// Three lanes divide each magnitude by the length, one quotient bit per
// stage, rounding to nearest with halves away from zero.
// ============================================================================
module ppr_div #(
  parameter int VEC_FRAC_BITS = 14
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [ppr_pkg::LEN_BITS-1:0]          len,
  input  ppr_pkg::ppr_side_t                    in_side,
  output logic                                  out_valid,
  output logic [2:0][VEC_FRAC_BITS:0]           quot,
  output ppr_pkg::ppr_side_t                    out_side
);
  import ppr_pkg::*;

  localparam int QB = VEC_FRAC_BITS + 1;
  localparam int RW = VEC_FRAC_BITS + MAG_BITS + 2 + 1;

  logic [RW-1:0]         rem  [QB+1][3];
  logic [QB-1:0]         q    [QB+1][3];
  logic [LEN_BITS-1:0]   dv   [QB+1];
  ppr_side_t             sd   [QB+1];
  logic [QB:0]           valid;

  // Divisor is twice the length; the numerator carries the rounding term.
  assign dv[0]    = {len[LEN_BITS-2:0], 1'b0};
  assign sd[0]    = in_side;
  assign valid[0] = in_valid;
  for (genvar i = 0; i < 3; i++) begin : g_init
    assign rem[0][i] = RW'({in_side.mag[i], {QB{1'b0}}}) + RW'(len);
    assign q[0][i]   = '0;
    assign quot[i]   = q[QB][i];
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int SH = QB - 1 - k;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (en) begin
        valid[k+1] <= valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1] <= dv[k];
        sd[k+1] <= sd[k];
      end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [RW-1:0] sub;
      assign sub = RW'(dv[k]) << SH;

      always_ff @(posedge clk) begin
        if (en) begin
          if (rem[k][i] >= sub) begin
            rem[k+1][i]   <= rem[k][i] - sub;
            q[k+1][i]     <= q[k][i] | (QB'(1) << SH);
          end else begin
            rem[k+1][i]   <= rem[k][i];
            q[k+1][i]     <= q[k][i];
          end
        end
      end
    end
  end

  assign out_valid = valid[QB];
  assign out_side  = sd[QB];

endmodule

/* hw/rtl/pinhole_primary_ray_direction_core.sv */
// ============================================================================
// pinhole_primary_ray_direction_core: pinhole camera primary ray directions
// Maps a jittered pixel to a unit ray direction through the camera basis.
// ============================================================================
// The core takes one pixel word per clock and returns one Q1.14 unit
// direction word per clock, in order, while the pipeline is not held. The
// 32 stage square root and the one bit per stage dividers make up most of
// the pipeline depth. The whole pipeline holds while a finished word in the
// last stage waits behind an unaccepted output word, even when earlier
// stages are empty; it moves again as soon as the output is taken or the
// last stage is empty. The configuration port is always ready and must be
// written only while the core holds no pixel in flight.
module pinhole_primary_ray_direction_core #(
  parameter int COORD_BITS    = 12,
  parameter int VEC_FRAC_BITS = 14,
  localparam int IN_RAW  = 2 * COORD_BITS + 2 * ppr_pkg::JIT_BITS,
  localparam int IN_W    = ((IN_RAW + 7) / 8) * 8,
  localparam int OUT_RAW = 3 * (VEC_FRAC_BITS + 2),
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // Fields from bit 0 up: pixel_x, pixel_y, jitter_x, jitter_y.
  input  logic [IN_W-1:0]                       s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // Fields from bit 0 up: dir_x, dir_y, dir_z.
  output logic [OUT_W-1:0]                      m_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ppr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [ppr_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import ppr_pkg::*;

  localparam int CB = VEC_FRAC_BITS + 2;
  localparam int QB = VEC_FRAC_BITS + 1;
  localparam logic [QB-1:0] QLIM = QB'(1) << VEC_FRAC_BITS;

  // Configuration registers.
  logic [CFG_DATA_BITS-1:0] right_vector, up_vector, forward_vector;
  logic [INV_BITS-1:0]      inv_width, inv_height;
  logic [SCALE_BITS-1:0]    tan_half_fov, aspect_ratio;

  logic en;
  logic ndc_valid, norm_valid, sqrt_valid, div_valid;
  logic signed [DXY_BITS-1:0] dx, dy;
  logic [SQ_BITS-1:0]  sumsq;
  logic [LEN_BITS-1:0] len;
  ppr_side_t norm_side, sqrt_side, div_side;
  logic [2:0][QB-1:0] quot;
  logic [2:0][CB-1:0] dir;
  logic [QB-1:0]      qc [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      right_vector   <= 48'h0000_0000_4000;
      up_vector      <= 48'h4000_0000_0000;
      forward_vector <= 48'h0000_4000_0000;
      inv_width      <= 25'h100_0000;
      inv_height     <= 25'h100_0000;
      tan_half_fov   <= 24'h01_0000;
      aspect_ratio   <= 24'h01_0000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RIGHT:   right_vector   <= cfg_data;
        REG_UP:      up_vector      <= cfg_data;
        REG_FORWARD: forward_vector <= cfg_data;
        REG_INV_W:   inv_width      <= cfg_data[INV_BITS-1:0];
        REG_INV_H:   inv_height     <= cfg_data[INV_BITS-1:0];
        REG_TAN:     tan_half_fov   <= cfg_data[SCALE_BITS-1:0];
        REG_ASPECT:  aspect_ratio   <= cfg_data[SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves unless a finished word would collide with a waiting one.
  assign en       = !m_tvalid || m_tready || !div_valid;
  assign s_tready = en;

  ppr_ndc #(.COORD_BITS(COORD_BITS)) u_ndc (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (s_tvalid),
    .pixel_x      (s_tdata[COORD_BITS-1:0]),
    .pixel_y      (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .jitter_x     (signed'(s_tdata[2*COORD_BITS +: JIT_BITS])),
    .jitter_y     (signed'(s_tdata[2*COORD_BITS+JIT_BITS +: JIT_BITS])),
    .inv_width    (inv_width),
    .inv_height   (inv_height),
    .tan_half_fov (tan_half_fov),
    .aspect_ratio (aspect_ratio),
    .out_valid    (ndc_valid),
    .dx           (dx),
    .dy           (dy)
  );

  ppr_norm #(.VEC_FRAC_BITS(VEC_FRAC_BITS)) u_norm (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (ndc_valid),
    .dx             (dx),
    .dy             (dy),
    .right_vector   (right_vector),
    .up_vector      (up_vector),
    .forward_vector (forward_vector),
    .out_valid      (norm_valid),
    .sumsq          (sumsq),
    .side           (norm_side)
  );

  ppr_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (norm_valid),
    .radicand  (sumsq),
    .in_side   (norm_side),
    .out_valid (sqrt_valid),
    .root      (len),
    .out_side  (sqrt_side)
  );

  ppr_div #(.VEC_FRAC_BITS(VEC_FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sqrt_valid),
    .len       (len),
    .in_side   (sqrt_side),
    .out_valid (div_valid),
    .quot      (quot),
    .out_side  (div_side)
  );

  // Clamp, restore the sign, and force zero for a degenerate vector.
  for (genvar i = 0; i < 3; i++) begin : g_out
    assign qc[i] = (quot[i] > QLIM) ? QLIM : quot[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      for (int i = 0; i < 3; i++) begin
        if (div_side.zero) begin
          dir[i] <= '0;
        end else if (div_side.neg[i]) begin
          dir[i] <= -{1'b0, qc[i]};
        end else begin
          dir[i] <= {1'b0, qc[i]};
        end
      end
    end
  end

  assign m_tdata = OUT_W'(dir);

endmodule
